// ===== hw/rtl/lmps_pkg.sv =====
package lmps_pkg;

    // Default sizing of the time counters and of the alpha fraction.
    localparam int TIME_BITS_DEF       = 24;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    // Height word width, fixed by the result field.
    localparam int HEIGHT_BITS = 24;

    // Width of the time-valued configuration registers.
    localparam int CFG_TIME_BITS = 24;

    // Configuration port geometry.
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_IDX_BITS-1:0] REG_MOVE_DURATION     = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_RISE_HEIGHT       = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_BASE_HEIGHT       = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_DWELL_DELAY       = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_USE_SMOOTHSTEP    = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_HIDE_PACK_AT_REST = 3'd5;

    // Register reset values.
    localparam logic [CFG_TIME_BITS-1:0]      RST_MOVE_DURATION     = 24'd1000000;
    localparam logic signed [HEIGHT_BITS-1:0] RST_RISE_HEIGHT       = 24'sd1600;
    localparam logic signed [HEIGHT_BITS-1:0] RST_BASE_HEIGHT       = 24'sd0;
    localparam logic [CFG_TIME_BITS-1:0]      RST_DWELL_DELAY       = 24'd500000;
    localparam logic                          RST_USE_SMOOTHSTEP    = 1'b1;
    localparam logic                          RST_HIDE_PACK_AT_REST = 1'b1;

    // Request kinds carried in the input tuser.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    // Motion phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_RISE   = 2'd1;
    localparam logic [1:0] PH_DWELL  = 2'd2;
    localparam logic [1:0] PH_RETURN = 2'd3;

    // Saturation limits, held two bits wider than the height word.
    localparam logic signed [HEIGHT_BITS+1:0] HEIGHT_MAX_W =
        (HEIGHT_BITS+2)'((1 << (HEIGHT_BITS-1)) - 1);
    localparam logic signed [HEIGHT_BITS+1:0] HEIGHT_MIN_W = -HEIGHT_MAX_W - 1;

    // Configuration register contents.
    typedef struct packed {
        logic [CFG_TIME_BITS-1:0]      move_duration;
        logic signed [HEIGHT_BITS-1:0] rise_height;
        logic signed [HEIGHT_BITS-1:0] base_height;
        logic [CFG_TIME_BITS-1:0]      dwell_delay;
        logic                          use_smoothstep;
        logic                          hide_pack_at_rest;
    } t_cfg;

    // Clamp a widened height to the signed height range.
    function automatic logic signed [HEIGHT_BITS-1:0] sat_height(
        input logic signed [HEIGHT_BITS+1:0] v
    );
        logic signed [HEIGHT_BITS-1:0] res;
        if (v > HEIGHT_MAX_W) begin
            res = HEIGHT_MAX_W[HEIGHT_BITS-1:0];
        end else if (v < HEIGHT_MIN_W) begin
            res = HEIGHT_MIN_W[HEIGHT_BITS-1:0];
        end else begin
            res = v[HEIGHT_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/lmps_regs.sv =====
module lmps_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lmps_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lmps_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lmps_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output lmps_pkg::t_cfg                      o_cfg
);

    lmps_pkg::t_cfg                      r_cfg;
    logic                                w_wr;
    logic [lmps_pkg::REG_IDX_BITS-1:0]   w_idx;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[lmps_pkg::APB_ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_duration     <= lmps_pkg::RST_MOVE_DURATION;
            r_cfg.rise_height       <= lmps_pkg::RST_RISE_HEIGHT;
            r_cfg.base_height       <= lmps_pkg::RST_BASE_HEIGHT;
            r_cfg.dwell_delay       <= lmps_pkg::RST_DWELL_DELAY;
            r_cfg.use_smoothstep    <= lmps_pkg::RST_USE_SMOOTHSTEP;
            r_cfg.hide_pack_at_rest <= lmps_pkg::RST_HIDE_PACK_AT_REST;
        end else if (w_wr) begin
            unique case (w_idx)
                lmps_pkg::REG_MOVE_DURATION: begin
                    r_cfg.move_duration <= pwdata[lmps_pkg::CFG_TIME_BITS-1:0];
                end
                lmps_pkg::REG_RISE_HEIGHT: begin
                    r_cfg.rise_height <= $signed(pwdata[lmps_pkg::HEIGHT_BITS-1:0]);
                end
                lmps_pkg::REG_BASE_HEIGHT: begin
                    r_cfg.base_height <= $signed(pwdata[lmps_pkg::HEIGHT_BITS-1:0]);
                end
                lmps_pkg::REG_DWELL_DELAY: begin
                    r_cfg.dwell_delay <= pwdata[lmps_pkg::CFG_TIME_BITS-1:0];
                end
                lmps_pkg::REG_USE_SMOOTHSTEP: begin
                    r_cfg.use_smoothstep <= pwdata[0];
                end
                lmps_pkg::REG_HIDE_PACK_AT_REST: begin
                    r_cfg.hide_pack_at_rest <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back, zero filled above each register.
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            lmps_pkg::REG_MOVE_DURATION: begin
                prdata = lmps_pkg::APB_DATA_BITS'(r_cfg.move_duration);
            end
            lmps_pkg::REG_RISE_HEIGHT: begin
                prdata = lmps_pkg::APB_DATA_BITS'(unsigned'(r_cfg.rise_height));
            end
            lmps_pkg::REG_BASE_HEIGHT: begin
                prdata = lmps_pkg::APB_DATA_BITS'(unsigned'(r_cfg.base_height));
            end
            lmps_pkg::REG_DWELL_DELAY: begin
                prdata = lmps_pkg::APB_DATA_BITS'(r_cfg.dwell_delay);
            end
            lmps_pkg::REG_USE_SMOOTHSTEP: begin
                prdata = lmps_pkg::APB_DATA_BITS'(r_cfg.use_smoothstep);
            end
            lmps_pkg::REG_HIDE_PACK_AT_REST: begin
                prdata = lmps_pkg::APB_DATA_BITS'(r_cfg.hide_pack_at_rest);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lmps_mul.sv =====
module lmps_mul #(
    parameter int MW = 27
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [MW-1:0]   i_a,
    input  logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0] o_prod
);

    logic signed [2*MW-1:0] r_prod;

    assign o_prod = r_prod;

    // Shared signed multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

endmodule

// ===== hw/rtl/lift_motion_profile_sequencer_unit.sv =====
// Channel   Direction  Signals                       Contents
// request   in         s_axis_tvalid/tready/tdata    tdata delta_time, tuser mode
// result    out        m_axis_tvalid/tready/tdata    height, phase, installing, pack
// config    in/out     psel/penable/pwrite/paddr...  six registers at 4*index
//
// A tick in a rise or a return steps through accept, one divider step per alpha
// bit (none when the move ends), the smoothstep states SQ, EA and EB with two
// multiplies (skipped when linear), then lerp, quotient, update and output.
// Other requests go from accept straight to output. Input is ready
// only in idle; one result may wait in the output register while the next runs.
// Synchronous active-low reset puts the lift at rest at the reset base height.
module lift_motion_profile_sequencer_unit #(
    parameter int TIME_BITS       = lmps_pkg::TIME_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = lmps_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] delta_time
    input  logic [1:0]                          s_axis_tuser,  // [1:0] mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [23:0] lift_height, [25:24] phase, [26] installing, [27] pack_visible
    output logic [31:0]                         m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lmps_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lmps_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lmps_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int TW  = TIME_BITS;
    localparam int F   = ALPHA_FRAC_BITS;
    localparam int AW  = F + 1;
    localparam int HB  = lmps_pkg::HEIGHT_BITS;
    localparam int MW  = (F + 3 > HB + 2) ? F + 3 : HB + 2;
    localparam int PW  = 2 * MW;
    localparam int CW  = $clog2(F);

    localparam logic [AW-1:0]        ALPHA_ONE  = AW'(1) << F;
    localparam logic [MW-1:0]        THREE_ONE  = MW'(3) << F;
    localparam logic signed [PW-1:0] ROUND_BIAS = $signed(PW'((64'd1 << F) - 64'd1));

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIV  = 9'b000000010,
        ST_SQ   = 9'b000000100,
        ST_EA   = 9'b000001000,
        ST_EB   = 9'b000010000,
        ST_LERP = 9'b000100000,
        ST_QUO  = 9'b001000000,
        ST_FIN  = 9'b010000000,
        ST_EMIT = 9'b100000000
    } t_state;

    lmps_pkg::t_cfg          w_cfg;

    t_state                  r_state;
    logic [1:0]              r_phase;
    logic [TW-1:0]           r_move_el;
    logic [TW-1:0]           r_dwell_el;
    logic                    r_install;
    logic                    r_pack;
    logic signed [HB-1:0]    r_height;
    logic                    r_out_valid;
    logic [31:0]             r_out_data;

    logic [TW-1:0]           r_rem;
    logic [AW-1:0]           r_alpha;
    logic [CW-1:0]           r_cnt;
    logic signed [HB:0]      r_q;

    logic                    w_accept;
    logic                    w_emit;
    logic [1:0]              w_mode;
    logic [TW-1:0]           w_dur;
    logic [TW-1:0]           w_lim;
    logic [TW:0]             w_move_sum;
    logic [TW-1:0]           w_e;
    logic [TW:0]             w_dwell_sum;
    logic [TW-1:0]           w_d;
    logic [TW:0]             w_rem2;
    logic                    w_ge;
    logic [TW-1:0]           w_rem_next;
    logic signed [HB-1:0]    w_base;
    logic signed [HB-1:0]    w_top;
    logic signed [HB-1:0]    w_start;
    logic signed [HB+1:0]    w_travel;
    logic signed [HB+1:0]    w_sum;
    logic                    w_mul_en;
    logic signed [MW-1:0]    w_mul_a;
    logic signed [MW-1:0]    w_mul_b;
    logic signed [PW-1:0]    w_prod;
    logic signed [PW-1:0]    w_bias;
    logic signed [PW-1:0]    w_quo;
    logic signed [MW-1:0]    w_alpha_ext;

    lmps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lmps_mul #(
        .MW (MW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Handshake and request decode.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_mode        = s_axis_tuser;
    assign w_emit        = (r_state == ST_EMIT) & (~r_out_valid | m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Time limits and clamped elapsed counts.
    assign w_dur       = TW'(w_cfg.move_duration);
    assign w_lim       = TW'(w_cfg.dwell_delay);
    assign w_move_sum  = {1'b0, r_move_el} + (TW+1)'(s_axis_tdata);
    assign w_e         = (w_move_sum > {1'b0, w_dur}) ? w_dur : w_move_sum[TW-1:0];
    assign w_dwell_sum = {1'b0, r_dwell_el} + (TW+1)'(s_axis_tdata);
    assign w_d         = (w_dwell_sum > {1'b0, w_lim}) ? w_lim : w_dwell_sum[TW-1:0];

    // One restoring divider step: the remainder stays below the duration.
    assign w_rem2     = {r_rem, 1'b0};
    assign w_ge       = (w_rem2 >= {1'b0, w_dur});
    assign w_rem_next = w_ge ? TW'(w_rem2 - {1'b0, w_dur}) : w_rem2[TW-1:0];

    // End points of the travel.
    assign w_base   = w_cfg.base_height;
    assign w_top    = lmps_pkg::sat_height((HB+2)'(w_cfg.base_height)
                                           + (HB+2)'(w_cfg.rise_height));
    assign w_start  = (r_phase == lmps_pkg::PH_RISE) ? w_base : w_top;
    assign w_travel = (r_phase == lmps_pkg::PH_RISE)
                    ? (HB+2)'(w_top) - (HB+2)'(w_base)
                    : (HB+2)'(w_base) - (HB+2)'(w_top);
    assign w_sum    = (HB+2)'(w_start) + (HB+2)'(r_q);

    // Quotient by the alpha scale, truncated toward zero.
    assign w_bias = w_prod[PW-1] ? (w_prod + ROUND_BIAS) : w_prod;
    assign w_quo  = w_bias >>> F;

    assign w_alpha_ext = $signed(MW'(r_alpha));

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            ST_SQ: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_alpha_ext;
                w_mul_b  = w_alpha_ext;
            end
            ST_EA: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed(MW'(w_prod[F +: AW]));
                w_mul_b  = $signed(THREE_ONE - {w_alpha_ext[MW-2:0], 1'b0});
            end
            ST_LERP: begin
                w_mul_en = 1'b1;
                w_mul_a  = MW'(w_travel);
                w_mul_b  = w_alpha_ext;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer and motion state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= lmps_pkg::PH_IDLE;
            r_move_el   <= '0;
            r_dwell_el  <= '0;
            r_install   <= 1'b0;
            r_pack      <= ~lmps_pkg::RST_HIDE_PACK_AT_REST;
            r_height    <= lmps_pkg::RST_BASE_HEIGHT;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills on emit and empties when taken.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= (w_mode == lmps_pkg::MODE_TICK
                                    && (r_phase == lmps_pkg::PH_RISE
                                        || r_phase == lmps_pkg::PH_RETURN))
                                 ? ST_DIV : ST_EMIT;
                        unique case (w_mode)
                            lmps_pkg::MODE_TICK: begin
                                if (r_phase == lmps_pkg::PH_RISE
                                    || r_phase == lmps_pkg::PH_RETURN) begin
                                    r_move_el <= w_e;
                                end else if (r_phase == lmps_pkg::PH_DWELL
                                             && w_lim != '0) begin
                                    r_dwell_el <= w_d;
                                    if (w_d == w_lim) begin
                                        r_pack    <= 1'b0;
                                        r_phase   <= lmps_pkg::PH_RETURN;
                                        r_move_el <= '0;
                                        r_height  <= w_top;
                                    end
                                end
                            end
                            lmps_pkg::MODE_START: begin
                                if (!r_install) begin
                                    r_install  <= 1'b1;
                                    r_pack     <= 1'b1;
                                    r_phase    <= lmps_pkg::PH_RISE;
                                    r_move_el  <= '0;
                                    r_dwell_el <= '0;
                                    r_height   <= w_base;
                                end
                            end
                            lmps_pkg::MODE_RESET: begin
                                r_phase    <= lmps_pkg::PH_IDLE;
                                r_move_el  <= '0;
                                r_dwell_el <= '0;
                                r_install  <= 1'b0;
                                r_pack     <= ~w_cfg.hide_pack_at_rest;
                                r_height   <= w_base;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (r_alpha[F] || r_cnt == CW'(F - 1)) begin
                        r_state <= w_cfg.use_smoothstep ? ST_SQ : ST_LERP;
                    end
                end
                ST_SQ: begin
                    r_state <= ST_EA;
                end
                ST_EA: begin
                    r_state <= ST_EB;
                end
                ST_EB: begin
                    r_state <= ST_LERP;
                end
                ST_LERP: begin
                    r_state <= ST_QUO;
                end
                ST_QUO: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_state <= ST_EMIT;
                    if (r_move_el == w_dur) begin
                        if (r_phase == lmps_pkg::PH_RISE) begin
                            r_phase    <= lmps_pkg::PH_DWELL;
                            r_dwell_el <= '0;
                            r_height   <= w_top;
                        end else begin
                            r_phase   <= lmps_pkg::PH_IDLE;
                            r_move_el <= '0;
                            r_install <= 1'b0;
                            r_height  <= w_base;
                        end
                    end else begin
                        r_height <= lmps_pkg::sat_height(w_sum);
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Divider, alpha and quotient registers, and the result word.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_rem   <= w_e;
            r_alpha <= (w_e == w_dur) ? ALPHA_ONE : '0;
            r_cnt   <= '0;
        end
        if (r_state == ST_DIV && !r_alpha[F]) begin
            r_rem   <= w_rem_next;
            r_alpha <= {r_alpha[AW-2:0], w_ge};
            r_cnt   <= r_cnt + CW'(1);
        end
        if (r_state == ST_EB) begin
            r_alpha <= w_prod[F +: AW];
        end
        if (r_state == ST_QUO) begin
            r_q <= w_quo[HB:0];
        end
        if (w_emit) begin
            r_out_data <= {4'b0000, r_pack, r_install, r_phase, r_height};
        end
    end

endmodule
